### rtl/bihf_pkg.sv
`timescale 1ns / 1ps

package bihf_pkg;

  typedef struct packed {
    logic signed [31:0] accel_magnitude;
    logic signed [31:0] accel_baseline;
    logic        [15:0] time_step;
    logic signed [31:0] pressure_diff;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fused_height;
    logic signed [31:0] fused_velocity;
    logic               baro_updated;
  } out_item_t;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 31;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_THRESHOLD = 3'd0,
    CFG_VEL_GAIN_HIGH   = 3'd1,
    CFG_VEL_GAIN_LOW    = 3'd2,
    CFG_HEIGHT_GAIN     = 3'd3,
    CFG_BARO_VEL_GAIN   = 3'd4,
    CFG_PRESSURE_SCALE  = 3'd5,
    CFG_BARO_PERIOD     = 3'd6
  } cfg_idx_e;

  localparam logic [30:0]       AccelThresholdRst = 31'd131072;
  localparam logic [15:0]       VelGainHighRst    = 16'd786;
  localparam logic [15:0]       VelGainLowRst     = 16'd197;
  localparam logic [15:0]       HeightGainRst     = 16'd1311;
  localparam logic [15:0]       BaroVelGainRst    = 16'd6554;
  localparam logic signed [7:0] PressureScaleRst  = -8'sd10;
  localparam logic [7:0]        BaroPeriodRst     = 8'd7;
  localparam logic [7:0]        TickCountRst      = 8'd1;

  // radix-2 divider: 33-bit magnitude shifted left by 16 gives a 49-bit dividend
  localparam int unsigned DivSteps = 49;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_MUL_DEVDT,
    OP_ACC_VEL,
    OP_MUL_VBLEND,
    OP_ACC_VBLEND,
    OP_MUL_VDT,
    OP_ACC_HGT,
    OP_MUL_HBLEND,
    OP_ACC_HBLEND,
    OP_MUL_PRESS,
    OP_BARO,
    OP_DIV,
    OP_QSAT,
    OP_MUL_BVEL,
    OP_ACC_BVEL,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    logic upd_hit;
    logic ts_zero;
    logic div_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/bihf_ctrl.sv
`timescale 1ns / 1ps

module bihf_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bihf_pkg::dp_status_t sts_i,
  output bihf_pkg::dp_op_e     op_o
);

  typedef enum logic [15:0] {
    ST_IDLE = 16'h0001,
    ST_M1   = 16'h0002,
    ST_A1   = 16'h0004,
    ST_M2   = 16'h0008,
    ST_A2   = 16'h0010,
    ST_M3   = 16'h0020,
    ST_A3   = 16'h0040,
    ST_M4   = 16'h0080,
    ST_A4   = 16'h0100,
    ST_M5   = 16'h0200,
    ST_A5   = 16'h0400,
    ST_DIV  = 16'h0800,
    ST_QSAT = 16'h1000,
    ST_M6   = 16'h2000,
    ST_A6   = 16'h4000,
    ST_FIN  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = bihf_pkg::OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_o    = bihf_pkg::OP_CAPTURE;
          state_d = ST_M1;
        end
      end
      ST_M1: begin
        op_o    = bihf_pkg::OP_MUL_DEVDT;
        state_d = ST_A1;
      end
      ST_A1: begin
        op_o    = bihf_pkg::OP_ACC_VEL;
        state_d = ST_M2;
      end
      ST_M2: begin
        op_o    = bihf_pkg::OP_MUL_VBLEND;
        state_d = ST_A2;
      end
      ST_A2: begin
        op_o    = bihf_pkg::OP_ACC_VBLEND;
        state_d = ST_M3;
      end
      ST_M3: begin
        op_o    = bihf_pkg::OP_MUL_VDT;
        state_d = ST_A3;
      end
      ST_A3: begin
        op_o    = bihf_pkg::OP_ACC_HGT;
        state_d = ST_M4;
      end
      ST_M4: begin
        op_o    = bihf_pkg::OP_MUL_HBLEND;
        state_d = ST_A4;
      end
      ST_A4: begin
        op_o    = bihf_pkg::OP_ACC_HBLEND;
        state_d = sts_i.upd_hit ? ST_M5 : ST_FIN;
      end
      ST_M5: begin
        op_o    = bihf_pkg::OP_MUL_PRESS;
        state_d = ST_A5;
      end
      ST_A5: begin
        // no elapsed time: baro velocity is held, skip the quotient
        op_o    = bihf_pkg::OP_BARO;
        state_d = sts_i.ts_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        op_o = bihf_pkg::OP_DIV;
        if (sts_i.div_last) begin
          state_d = ST_QSAT;
        end
      end
      ST_QSAT: begin
        op_o    = bihf_pkg::OP_QSAT;
        state_d = ST_M6;
      end
      ST_M6: begin
        op_o    = bihf_pkg::OP_MUL_BVEL;
        state_d = ST_A6;
      end
      ST_A6: begin
        op_o    = bihf_pkg::OP_ACC_BVEL;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          op_o    = bihf_pkg::OP_FINISH;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

### rtl/bihf_dp.sv
`timescale 1ns / 1ps

module bihf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bihf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [bihf_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  bihf_pkg::in_item_t                  in_data_i,
  input  bihf_pkg::dp_op_e                    op_i,
  output bihf_pkg::dp_status_t                sts_o,
  input  logic                                out_stall_i,
  output logic                                out_valid_o,
  output bihf_pkg::out_item_t                 out_data_o
);

  function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
    logic signed [31:0] r;
    if (x > 50'sh0_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -50'sh0_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // configuration
  logic        [30:0] thr_q;
  logic        [15:0] gain_hi_q, gain_lo_q, hgt_gain_q, bv_gain_q;
  logic signed [7:0]  scale_q;
  logic        [7:0]  period_q;

  // filter state
  logic signed [31:0] vel_q, hgt_q, bh_q, bv_q;
  logic        [31:0] ts_q;
  logic        [7:0]  tick_q;
  logic               out_valid_q;

  // per-item working registers
  logic signed [31:0] dev_q, pd_q, quot_q;
  logic        [15:0] dt_q;
  logic signed [49:0] prod_q;
  logic        [48:0] num_q;
  logic        [31:0] rem_q;
  logic [bihf_pkg::DivCntW-1:0] cnt_q;
  logic               neg_q, upd_q;
  bihf_pkg::out_item_t out_q;

  // combinational
  logic signed [32:0] in_diff;
  logic        [31:0] dev_abs;
  logic               dev_big;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] mul_p;
  logic signed [49:0] prod_rnd;
  logic signed [31:0] acc_base;
  logic signed [34:0] acc_sum;
  logic signed [31:0] acc_res;
  logic        [32:0] ts_sum;
  logic signed [31:0] new_bh;
  logic signed [32:0] bh_diff;
  logic        [32:0] bh_mag;
  logic        [32:0] div_shift;
  logic               div_ge;
  logic        [32:0] div_sub;
  logic               q_over_pos, q_over_neg;
  logic signed [31:0] q_sat;

  assign in_diff = 33'(in_data_i.accel_magnitude) - 33'(in_data_i.accel_baseline);
  assign dev_abs = dev_q[31] ? 32'(-dev_q) : 32'(dev_q);
  assign dev_big = dev_abs > {1'b0, thr_q};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_i)
      bihf_pkg::OP_MUL_DEVDT: begin
        mul_a = 33'(dev_q);
        mul_b = {1'b0, dt_q};
      end
      bihf_pkg::OP_MUL_VBLEND: begin
        mul_a = 33'(bv_q) - 33'(vel_q);
        mul_b = {1'b0, (dev_big ? gain_hi_q : gain_lo_q)};
      end
      bihf_pkg::OP_MUL_VDT: begin
        mul_a = 33'(vel_q);
        mul_b = {1'b0, dt_q};
      end
      bihf_pkg::OP_MUL_HBLEND: begin
        mul_a = 33'(bh_q) - 33'(hgt_q);
        mul_b = {1'b0, hgt_gain_q};
      end
      bihf_pkg::OP_MUL_PRESS: begin
        mul_a = 33'(pd_q);
        mul_b = 17'(scale_q);
      end
      bihf_pkg::OP_MUL_BVEL: begin
        mul_a = 33'(quot_q) - 33'(bv_q);
        mul_b = {1'b0, bv_gain_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round half up to Q16.16, then add onto the selected state and saturate
  assign prod_rnd = (prod_q + 50'sd32768) >>> 16;

  always_comb begin
    case (op_i)
      bihf_pkg::OP_ACC_HGT,
      bihf_pkg::OP_ACC_HBLEND: acc_base = hgt_q;
      bihf_pkg::OP_ACC_BVEL:   acc_base = bv_q;
      default:                 acc_base = vel_q;
    endcase
  end

  assign acc_sum = 35'(acc_base) + 35'($signed(prod_rnd[33:0]));
  assign acc_res = sat32(50'(acc_sum));

  assign ts_sum = {1'b0, ts_q} + 33'(dt_q);

  assign new_bh  = sat32(prod_q);
  assign bh_diff = 33'(new_bh) - 33'(bh_q);
  assign bh_mag  = bh_diff[32] ? 33'(-bh_diff) : 33'(bh_diff);

  assign div_shift = {rem_q, num_q[48]};
  assign div_ge    = div_shift >= {1'b0, ts_q};
  assign div_sub   = div_shift - {1'b0, ts_q};

  assign q_over_pos = (num_q[48:31] != '0);
  assign q_over_neg = (num_q[48:32] != '0) || (num_q[31] && (num_q[30:0] != '0));

  always_comb begin
    if (!neg_q) begin
      q_sat = q_over_pos ? 32'sh7FFF_FFFF : num_q[31:0];
    end else begin
      q_sat = q_over_neg ? 32'sh8000_0000 : 32'(-num_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= bihf_pkg::AccelThresholdRst;
      gain_hi_q  <= bihf_pkg::VelGainHighRst;
      gain_lo_q  <= bihf_pkg::VelGainLowRst;
      hgt_gain_q <= bihf_pkg::HeightGainRst;
      bv_gain_q  <= bihf_pkg::BaroVelGainRst;
      scale_q    <= bihf_pkg::PressureScaleRst;
      period_q   <= bihf_pkg::BaroPeriodRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bihf_pkg::CFG_ACCEL_THRESHOLD: thr_q      <= cfg_wdata_i[30:0];
        bihf_pkg::CFG_VEL_GAIN_HIGH:   gain_hi_q  <= cfg_wdata_i[15:0];
        bihf_pkg::CFG_VEL_GAIN_LOW:    gain_lo_q  <= cfg_wdata_i[15:0];
        bihf_pkg::CFG_HEIGHT_GAIN:     hgt_gain_q <= cfg_wdata_i[15:0];
        bihf_pkg::CFG_BARO_VEL_GAIN:   bv_gain_q  <= cfg_wdata_i[15:0];
        bihf_pkg::CFG_PRESSURE_SCALE:  scale_q    <= cfg_wdata_i[7:0];
        bihf_pkg::CFG_BARO_PERIOD:     period_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q       <= '0;
      hgt_q       <= '0;
      bh_q        <= '0;
      bv_q        <= '0;
      ts_q        <= '0;
      tick_q      <= bihf_pkg::TickCountRst;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == bihf_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (op_i)
        bihf_pkg::OP_ACC_VEL: begin
          vel_q <= acc_res;
        end
        bihf_pkg::OP_ACC_VBLEND: begin
          vel_q <= acc_res;
          ts_q  <= ts_sum[32] ? '1 : ts_sum[31:0];
        end
        bihf_pkg::OP_ACC_HGT,
        bihf_pkg::OP_ACC_HBLEND: begin
          hgt_q <= acc_res;
        end
        bihf_pkg::OP_BARO: begin
          bh_q <= new_bh;
        end
        bihf_pkg::OP_ACC_BVEL: begin
          bv_q <= acc_res;
        end
        bihf_pkg::OP_FINISH: begin
          if (upd_q) begin
            tick_q <= bihf_pkg::TickCountRst;
            ts_q   <= '0;
          end else begin
            tick_q <= tick_q + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      bihf_pkg::OP_CAPTURE: begin
        dev_q <= sat32(50'(in_diff));
        dt_q  <= in_data_i.time_step;
        pd_q  <= in_data_i.pressure_diff;
      end
      bihf_pkg::OP_MUL_DEVDT,
      bihf_pkg::OP_MUL_VBLEND,
      bihf_pkg::OP_MUL_VDT,
      bihf_pkg::OP_MUL_HBLEND,
      bihf_pkg::OP_MUL_PRESS,
      bihf_pkg::OP_MUL_BVEL: begin
        prod_q <= mul_p;
      end
      bihf_pkg::OP_ACC_HBLEND: begin
        upd_q <= sts_o.upd_hit;
      end
      bihf_pkg::OP_BARO: begin
        neg_q <= bh_diff[32];
        num_q <= {bh_mag, 16'h0000};
        rem_q <= '0;
        cnt_q <= bihf_pkg::DivCntW'(bihf_pkg::DivSteps - 1);
      end
      bihf_pkg::OP_DIV: begin
        rem_q <= div_ge ? div_sub[31:0] : div_shift[31:0];
        num_q <= {num_q[47:0], div_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      bihf_pkg::OP_QSAT: begin
        quot_q <= q_sat;
      end
      bihf_pkg::OP_FINISH: begin
        out_q.fused_height   <= hgt_q;
        out_q.fused_velocity <= vel_q;
        out_q.baro_updated   <= upd_q;
      end
      default: ;
    endcase
  end

  assign sts_o.upd_hit  = (tick_q == period_q);
  assign sts_o.ts_zero  = (ts_q == '0);
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/baro_inertial_height_fusion.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 beat
// in        sink       in_valid_i / in_stall_o   bihf_pkg::in_item_t
// out       source     out_valid_o / out_stall_i bihf_pkg::out_item_t
// cfg       sink       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Plain tick: an accept step, 8 steps on one shared 33x17 multiplier (each
// product registered), then a finish step.
// Baro tick: with zero accumulated time no quotient is formed; else the radix-2
// divider takes 49 steps for the height-change quotient.
// Reset is asynchronous, active low; filter state and config load at once.
// A waiting result in the output register does not block the next beat; only
// the finish step waits for the output register to drain.

module baro_inertial_height_fusion (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bihf_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bihf_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  bihf_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output bihf_pkg::out_item_t           out_data_o
);

  bihf_pkg::dp_op_e     op;
  bihf_pkg::dp_status_t sts;

  bihf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .op_o       (op)
  );

  bihf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .op_i        (op),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### rtl/bihf_checker.sv
`timescale 1ns / 1ps

module bihf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_i,
  input logic                out_valid_i,
  input logic                out_stall_i,
  input bihf_pkg::out_item_t out_data_i
);

  // one tick at a time: after a beat is taken the input stays stalled
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i ##1 in_stall_i ##1 in_stall_i)
    else $error("input not stalled while a tick is in work");

  // a result appears only at the end of a tick, while the input is stalled
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_stall_i))
    else $error("result appeared without a tick in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result dropped or changed");

endmodule

bind baro_inertial_height_fusion bihf_checker u_bihf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
